// File: sv/rlcg_pkg.sv
// Shared types, op codes and arithmetic helpers for the 48-bit rand48 generator.
// Holds the request and response beat structs, the recurrence and the binary64 fraction encoder.
// No dependencies.
`default_nettype none

package rlcg_pkg;

   localparam int STATE_W = 48;

   // Op codes carried in the request beat.
   localparam logic [2:0] OP_SEED       = 3'd0;
   localparam logic [2:0] OP_INT_DOUBLE = 3'd1;
   localparam logic [2:0] OP_INT_NN31   = 3'd2;
   localparam logic [2:0] OP_INT_U32    = 3'd3;
   localparam logic [2:0] OP_EXT_DOUBLE = 3'd4;
   localparam logic [2:0] OP_EXT_NN31   = 3'd5;
   localparam logic [2:0] OP_EXT_U32    = 3'd6;
   localparam logic [2:0] OP_UNUSED     = 3'd7;

   // How the value is taken from the new state.
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_FRAC = 2'd1;
   localparam logic [1:0] KIND_NN31 = 2'd2;
   localparam logic [1:0] KIND_U32  = 2'd3;

   localparam logic [STATE_W-1:0] RESET_STATE = 48'h1234_ABCD_330E;
   localparam logic [15:0]        SEED_LOW    = 16'h330E;
   // Multiplier 0x5_DEEC_E66D split into its low 32 bits and the upper 3 bits.
   localparam logic [31:0]        MULT_LOW    = 32'hDEEC_E66D;
   localparam logic [15:0]        MULT_LOW16  = 16'hE66D;
   localparam logic [15:0]        MULT_TOP    = 16'h0005;
   localparam logic [STATE_W-1:0] ADD_CONST   = 48'h0000_0000_000B;
   localparam logic [10:0]        EXP_BASE    = 11'd1022;

   typedef struct packed {
      logic [2:0]         op;
      logic [31:0]        seed_value;
      logic [STATE_W-1:0] ext_state;
   } req_type;

   typedef struct packed {
      logic [63:0]        value;
      logic [STATE_W-1:0] new_ext_state;
   } rsp_type;

   // One step of x' = (0x5DEECE66D * x + 0xB) mod 2^48. Only the low 48 bits of
   // the product matter, so the upper 16 bits of x meet only the low 16 bits of
   // the multiplier, and the multiplier's top bits meet only the low 16 bits of x.
   function automatic logic [STATE_W-1:0] lcg_next(input logic [STATE_W-1:0] x);
      logic [63:0] lo_prod;
      logic [15:0] hi_add;
      begin
         lo_prod = {32'd0, x[31:0]} * {32'd0, MULT_LOW};
         hi_add  = 16'(x[47:32] * MULT_LOW16) + 16'(x[15:0] * MULT_TOP);
         lcg_next = lo_prod[47:0] + {hi_add, 32'd0} + ADD_CONST;
      end
   endfunction

   // Exact binary64 encoding of s / 2^48, by a six-step normalising shift.
   function automatic logic [63:0] to_fraction_bits(input logic [STATE_W-1:0] s);
      logic [STATE_W-1:0] n;
      logic [5:0]         lz;
      begin
         n  = s;
         lz = 6'd0;
         if (n[47:16] == 32'd0) begin
            n  = {n[15:0], 32'd0};
            lz = lz + 6'd32;
         end
         if (n[47:32] == 16'd0) begin
            n  = {n[31:0], 16'd0};
            lz = lz + 6'd16;
         end
         if (n[47:40] == 8'd0) begin
            n  = {n[39:0], 8'd0};
            lz = lz + 6'd8;
         end
         if (n[47:44] == 4'd0) begin
            n  = {n[43:0], 4'd0};
            lz = lz + 6'd4;
         end
         if (n[47:46] == 2'd0) begin
            n  = {n[45:0], 2'd0};
            lz = lz + 6'd2;
         end
         if (n[47] == 1'b0) begin
            n  = {n[46:0], 1'b0};
            lz = lz + 6'd1;
         end
         if (s == '0) begin
            to_fraction_bits = 64'd0;
         end else begin
            to_fraction_bits = {1'b0, EXP_BASE - 11'(lz), n[46:0], 5'd0};
         end
      end
   endfunction

endpackage

`default_nettype wire

// File: sv/rand48_lcg_generator.sv
// Top level of the 48-bit rand48 linear congruential generator.
// Three-register pipeline: request register, multiply-add stage, result register.
// Depends on rlcg_pkg for the beat structs, op codes and arithmetic helpers.
//
//   channel  | handshake             | payload                 | direction
//   ---------+-----------------------+-------------------------+----------
//   request  | req_valid / req_ready | req_data (req_type)     | in
//   response | rsp_valid / rsp_ready | rsp_data (rsp_type)     | out
//
// Every request beat gives exactly one response beat once it has passed the step
// and result registers. A new beat is taken every cycle while req_ready is high.
// The stages are set by the recurrence: the internal state goes through one
// constant multiply-add per cycle, and the binary64 encoding gets a stage of its own.
// Reset (synchronous, active high) empties the pipeline and loads the internal
// state with 0x1234ABCD330E.
// A stall on the response side holds each stage in place; stages behind a free
// one still move up, so req_ready stays high while any stage has room.
`default_nettype none

module rand48_lcg_generator
   import rlcg_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   // Request register: holds the beat just accepted.
   logic                 s1_valid_ff;
   req_type              s1_req_ff;

   // Step register: the new state and how the value is to be taken from it.
   logic                 s2_valid_ff;
   logic [STATE_W-1:0]   s2_state_ff;
   logic [STATE_W-1:0]   s2_state_in;
   logic [1:0]           s2_kind_ff;
   logic [1:0]           s2_kind_in;
   logic                 s2_ext_ff;
   logic                 s2_ext_in;

   // Result register, facing the response channel.
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;
   rsp_type              rsp_data_in;

   // Internal generator state.
   logic [STATE_W-1:0]   gen_state_ff;
   logic [STATE_W-1:0]   gen_state_in;

   logic                 rsp_free;
   logic                 s2_free;
   logic                 s1_move;
   logic                 s2_move;
   logic [STATE_W-1:0]   step_src;

   // Each stage may take a new beat when it is empty or its beat moves on in
   // this same cycle.
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign s2_move   = s2_valid_ff && rsp_free;
   assign s2_free   = !s2_valid_ff || rsp_free;
   assign s1_move   = s1_valid_ff && s2_free;
   assign req_ready = !s1_valid_ff || s2_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The external ops step the caller's state; the internal ops step our own, and a seed op loads it.
   always_comb begin
      step_src     = gen_state_ff;
      s2_kind_in   = KIND_NONE;
      s2_ext_in    = 1'b0;
      gen_state_in = gen_state_ff;
      unique case (s1_req_ff.op) inside
         OP_SEED: begin
            gen_state_in = {s1_req_ff.seed_value, SEED_LOW};
         end
         OP_INT_DOUBLE, OP_INT_NN31, OP_INT_U32: begin
            s2_kind_in = s1_req_ff.op[1:0];
         end
         OP_EXT_DOUBLE, OP_EXT_NN31, OP_EXT_U32: begin
            step_src   = s1_req_ff.ext_state;
            s2_ext_in  = 1'b1;
            s2_kind_in = 2'(s1_req_ff.op - 3'd3);
         end
         default: begin
            s2_kind_in = KIND_NONE;
         end
      endcase
      s2_state_in = lcg_next(step_src);
      if ((s1_req_ff.op == OP_INT_DOUBLE) || (s1_req_ff.op == OP_INT_NN31) ||
          (s1_req_ff.op == OP_INT_U32)) begin
         gen_state_in = s2_state_in;
      end
   end

   // Value extraction from the new state. The kind codes match the low bits of
   // the internal op codes, which is what the decode above relies on.
   always_comb begin
      rsp_data_in.new_ext_state = s2_ext_ff ? s2_state_ff : '0;
      unique case (s2_kind_ff)
         KIND_FRAC: rsp_data_in.value = to_fraction_bits(s2_state_ff);
         KIND_NN31: rsp_data_in.value = {33'd0, s2_state_ff[47:17]};
         KIND_U32:  rsp_data_in.value = {32'd0, s2_state_ff[47:16]};
         default:   rsp_data_in.value = 64'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         gen_state_ff <= RESET_STATE;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (rsp_free) begin
            rsp_valid_ff <= s2_valid_ff;
         end
         // The internal state advances as a beat leaves the request register,
         // so beats see it strictly in arrival order.
         if (s1_move) begin
            gen_state_ff <= gen_state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_req_ff <= req_data;
      end
      if (s1_move) begin
         s2_state_ff <= s2_state_in;
         s2_kind_ff  <= s2_kind_in;
         s2_ext_ff   <= s2_ext_in;
      end
      if (s2_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTHESIS
   // The state register holds its reset value in the cycle after a reset edge.
   assert property (@(posedge clock) reset |=> (gen_state_ff == RESET_STATE))
      else $error("generator state not loaded by reset");

   // The internal state moves only when a seeding or internal op leaves the
   // request register.
   assert property (@(posedge clock) disable iff (reset)
      !(s1_move && ((s1_req_ff.op == OP_SEED) || (s1_req_ff.op == OP_INT_DOUBLE) ||
                    (s1_req_ff.op == OP_INT_NN31) || (s1_req_ff.op == OP_INT_U32)))
      |=> $stable(gen_state_ff))
      else $error("generator state changed without an internal op");

   // Every value is a fraction below one or a narrow integer, so its top
   // twelve bits never reach the exponent of 1.0.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.value[63:52] < 12'd1023))
      else $error("response value out of range");
`endif

endmodule

`default_nettype wire
